>>> hdl/xee_pkg.sv
// ---------------------------------------------------------------------------
// xee_pkg: shared types and constants of the XML entity escape encoder
// Holds the item descriptor passed from classifier to expander, the run
// length and character lookup functions, and queue sizing.
// ---------------------------------------------------------------------------
package xee_pkg;

  // Kind of run an input byte expands into
  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_QUOT,
    KIND_AMP,
    KIND_APOS,
    KIND_LT,
    KIND_GT,
    KIND_NUM
  } kind_e;

  // Descriptor queued between front and back
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  ch;    // byte for a one-byte run
    logic [3:0]  dig2;  // hundreds digit of a numeric entity
    logic [3:0]  dig1;  // tens digit
    logic [3:0]  dig0;  // ones digit
  } desc_t;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW       = 3;  // run positions 0..5

  // Source byte codes
  localparam logic [7:0] B_NUL   = 8'd0;
  localparam logic [7:0] B_QUOT  = 8'd34;
  localparam logic [7:0] B_AMP   = 8'd38;
  localparam logic [7:0] B_APOS  = 8'd39;
  localparam logic [7:0] B_LT    = 8'd60;
  localparam logic [7:0] B_GT    = 8'd62;
  localparam logic [7:0] B_SPACE = 8'd32;
  localparam logic [7:0] B_HIGH  = 8'd128;
  localparam logic [7:0] B_200   = 8'd200;
  localparam logic [7:0] B_100   = 8'd100;

  // Output characters
  localparam logic [7:0] C_AMP  = 8'h26;  // &
  localparam logic [7:0] C_SEMI = 8'h3b;  // ;
  localparam logic [7:0] C_HASH = 8'h23;  // #
  localparam logic [7:0] C_ZERO = 8'h30;  // 0
  localparam logic [7:0] C_Q    = 8'h71;
  localparam logic [7:0] C_U    = 8'h75;
  localparam logic [7:0] C_O    = 8'h6f;
  localparam logic [7:0] C_T    = 8'h74;
  localparam logic [7:0] C_A    = 8'h61;
  localparam logic [7:0] C_M    = 8'h6d;
  localparam logic [7:0] C_P    = 8'h70;
  localparam logic [7:0] C_S    = 8'h73;
  localparam logic [7:0] C_L    = 8'h6c;
  localparam logic [7:0] C_G    = 8'h67;

  // Number of bytes in the run of a descriptor
  function automatic logic [IdxW-1:0] run_len(input kind_e kind);
    logic [IdxW-1:0] len;
    unique case (kind)
      KIND_PASS: len = 3'd1;
      KIND_QUOT: len = 3'd6;
      KIND_AMP:  len = 3'd5;
      KIND_APOS: len = 3'd6;
      KIND_LT:   len = 3'd4;
      KIND_GT:   len = 3'd4;
      KIND_NUM:  len = 3'd6;
      default:   len = 3'd1;
    endcase
    return len;
  endfunction

  // Byte at position idx of the run of a descriptor
  function automatic logic [7:0] run_char(input desc_t d, input logic [IdxW-1:0] idx);
    logic [7:0] c;
    c = C_SEMI;
    if (idx == '0 && d.kind != KIND_PASS) begin
      c = C_AMP;
    end else begin
      unique case (d.kind)
        KIND_PASS: c = d.ch;
        KIND_QUOT: begin
          case (idx)
            3'd1:    c = C_Q;
            3'd2:    c = C_U;
            3'd3:    c = C_O;
            3'd4:    c = C_T;
            default: c = C_SEMI;
          endcase
        end
        KIND_AMP: begin
          case (idx)
            3'd1:    c = C_A;
            3'd2:    c = C_M;
            3'd3:    c = C_P;
            default: c = C_SEMI;
          endcase
        end
        KIND_APOS: begin
          case (idx)
            3'd1:    c = C_A;
            3'd2:    c = C_P;
            3'd3:    c = C_O;
            3'd4:    c = C_S;
            default: c = C_SEMI;
          endcase
        end
        KIND_LT: begin
          case (idx)
            3'd1:    c = C_L;
            3'd2:    c = C_T;
            default: c = C_SEMI;
          endcase
        end
        KIND_GT: begin
          case (idx)
            3'd1:    c = C_G;
            3'd2:    c = C_T;
            default: c = C_SEMI;
          endcase
        end
        KIND_NUM: begin
          case (idx)
            3'd1:    c = C_HASH;
            3'd2:    c = C_ZERO | {4'h0, d.dig2};
            3'd3:    c = C_ZERO | {4'h0, d.dig1};
            3'd4:    c = C_ZERO | {4'h0, d.dig0};
            default: c = C_SEMI;
          endcase
        end
        default: c = C_SEMI;
      endcase
    end
    return c;
  endfunction

endpackage

>>> hdl/xee_if.sv
// ---------------------------------------------------------------------------
// xee_if: item channels of the XML entity escape encoder
// Valid/ready channels for source bytes and for escaped run bytes.
// ---------------------------------------------------------------------------
interface xee_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface xee_run_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

>>> hdl/xee_front.sv
// ---------------------------------------------------------------------------
// xee_front: source byte classifier
// Accepts source bytes, drops end-of-string zeros, and turns every other
// byte into a run descriptor for the queue.
// ---------------------------------------------------------------------------
module xee_front (
  xee_byte_if.sink         src_i,
  input  logic             full_i,
  output logic             push_o,
  output xee_pkg::desc_t   desc_o
);
  import xee_pkg::*;

  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [7:0]  b;

  assign b = src_i.in_byte;

  // Accept whenever the queue has room; zero bytes produce nothing
  assign src_i.ready = !full_i;
  assign push_o      = src_i.valid && !full_i && (b != B_NUL);

  // Decimal digits for 128..255: hundreds is 1 or 2, tens via x*205>>11
  always_comb begin
    rem  = (b >= B_200) ? 7'(b - B_200) : 7'(b - B_100);
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
  end

  // Classification
  always_comb begin
    desc_o.ch   = b;
    desc_o.dig2 = (b >= B_200) ? 4'd2 : 4'd1;
    desc_o.dig1 = tens;
    desc_o.dig0 = 4'(rem - 7'(tens) * 7'd10);
    unique case (b)
      B_QUOT:  desc_o.kind = KIND_QUOT;
      B_AMP:   desc_o.kind = KIND_AMP;
      B_APOS:  desc_o.kind = KIND_APOS;
      B_LT:    desc_o.kind = KIND_LT;
      B_GT:    desc_o.kind = KIND_GT;
      default: begin
        if (b >= B_HIGH) begin
          desc_o.kind = KIND_NUM;
        end else if (b < B_SPACE) begin
          desc_o.kind = KIND_PASS;
          desc_o.ch   = B_SPACE;
        end else begin
          desc_o.kind = KIND_PASS;
        end
      end
    endcase
  end

endmodule

>>> hdl/xee_fifo.sv
// ---------------------------------------------------------------------------
// xee_fifo: descriptor queue
// Short register queue decoupling the classifier from the expander; the
// head is visible without a pop, and push and pop may share a cycle.
// ---------------------------------------------------------------------------
module xee_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  xee_pkg::desc_t desc_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output xee_pkg::desc_t head_o
);
  import xee_pkg::*;

  desc_t             mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue fill count out of range");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CntW'(QueueDepth)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with fill count");

endmodule

>>> hdl/xee_back.sv
// ---------------------------------------------------------------------------
// xee_back: run expander
// Walks the head descriptor into an output register one byte per cycle while
// the receiver takes them, and pops it when its last byte is loaded.
// ---------------------------------------------------------------------------
module xee_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  xee_pkg::desc_t       head_i,
  output logic                 pop_o,
  xee_run_if.source            dst_o
);
  import xee_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic            run_last_q;
  logic            load;
  logic            last;
  logic [IdxW-1:0] len;

  assign len   = run_len(head_i.kind);
  assign last  = (idx_q == IdxW'(len - 1'b1));
  assign load  = !empty_i && (!out_valid_q || dst_o.ready);
  assign pop_o = load && last;

  // Position counter and output valid
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = last ? '0 : IdxW'(idx_q + 1'b1);
      out_valid_d = 1'b1;
    end else if (dst_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= run_char(head_i, idx_q);
      run_last_q <= last;
    end
  end

  assign dst_o.valid    = out_valid_q;
  assign dst_o.out_byte = out_byte_q;
  assign dst_o.run_last = run_last_q;

  // Checks
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q < len)
    else $error("run position past end of run");
  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> idx_q == '0)
    else $error("run position left over with empty queue");
  a_last_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> run_last_q && out_valid_q)
    else $error("pop without final run byte");

endmodule

>>> hdl/xml_entity_escape_encoder.sv
// ---------------------------------------------------------------------------
// xml_entity_escape_encoder: byte stream to XML-safe text
// Top level joining classifier, descriptor queue and run expander.
// ---------------------------------------------------------------------------
// Usage:
//   src_i carries one source byte per item (in_byte). dst_o carries escaped
//   bytes (out_byte) with run_last set on the final byte of each byte's run.
//   Markup characters become named entities (4 to 6 bytes), bytes 128..255
//   become &#NNN; (6 bytes), control bytes a space, others pass through.
//   A zero byte is accepted and produces no output.
// Path: an accepted source byte is written into the queue; its first output
//   byte is loaded from the queue head, read combinationally, into the output register.
// Throughput: one output byte per cycle while dst_o.ready is high, set by the
//   expander's single output register; plain bytes therefore stream at one
//   item per cycle, and an entity run occupies the expander until all of its
//   bytes are out while the 4-entry queue keeps accepting.
// Stall: when dst_o.ready is low the output register holds; the queue fills
//   and src_i.ready drops once 4 descriptors are waiting.
// Reset: rst_ni (async, active low) empties the queue and the output stage.
// ---------------------------------------------------------------------------
module xml_entity_escape_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  xee_byte_if.sink   src_i,
  xee_run_if.source  dst_o
);
  import xee_pkg::*;

  desc_t desc;
  desc_t head;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;

  xee_front u_front (
    .src_i  (src_i),
    .full_i (full),
    .push_o (push),
    .desc_o (desc)
  );

  xee_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  xee_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .dst_o   (dst_o)
  );

endmodule

>>> verif/xee_escape_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xee_escape_checker: escaped-run checker for the XML entity escape encoder
// Watches both item channels, expands every accepted source byte into the
// run of bytes it must produce, and compares each accepted output item
// against the oldest expected byte. Reports the failure count and the
// number of bytes still owed to the testbench top.
// ---------------------------------------------------------------------------
module xee_escape_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  xee_byte_if   src_mon,
  xee_run_if    dst_mon,
  output int    fail_count_o,
  output int    owed_bytes_o
);

  import xee_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } escaped_t;

  // Bytes still owed by the block, oldest first
  escaped_t escaped_q[$];
  int       fail_cnt;

  initial begin
    fail_cnt     = 0;
    fail_count_o = 0;
    owed_bytes_o = 0;
  end

  // Expand one source byte into its escaped run
  task automatic expand_byte(input logic [7:0] b);
    string    text;
    escaped_t e;
    text = "";
    case (b)
      B_NUL:   text = "";  // end of string: nothing comes out
      B_QUOT:  text = "&quot;";
      B_AMP:   text = "&amp;";
      B_APOS:  text = "&apos;";
      B_LT:    text = "&lt;";
      B_GT:    text = "&gt;";
      default: begin
        if (b < B_SPACE) begin
          text = " ";
        end else if (b < B_HIGH) begin
          text = $sformatf("%c", b);
        end else begin
          text = $sformatf("&#%03d;", int'(b));
        end
      end
    endcase
    for (int i = 0; i < text.len(); i++) begin
      e.ch   = text[i];
      e.last = (i == text.len() - 1);
      escaped_q.push_back(e);
    end
  endtask

  // Compare output items first, then queue the run of the new source byte
  always @(posedge clk_i) begin
    escaped_t want;
    if (rst_ni) begin
      if (dst_mon.valid && dst_mon.ready) begin
        if (escaped_q.size() == 0) begin
          $display("%0t: unexpected item: out_byte %h run_last %b", $time,
                   dst_mon.out_byte, dst_mon.run_last);
          fail_cnt++;
        end else begin
          want = escaped_q.pop_front();
          if (dst_mon.out_byte !== want.ch) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.ch,
                     dst_mon.out_byte);
            fail_cnt++;
          end
          if (dst_mon.run_last !== want.last) begin
            $display("%0t: run_last expected %b actual %b (out_byte %h)", $time,
                     want.last, dst_mon.run_last, dst_mon.out_byte);
            fail_cnt++;
          end
        end
      end
      if (src_mon.valid && src_mon.ready) begin
        expand_byte(src_mon.in_byte);
      end
      fail_count_o <= fail_cnt;
      owed_bytes_o <= escaped_q.size();
    end
  end

endmodule

>>> verif/tb_xml_entity_escape_encoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_xml_entity_escape_encoder: testbench top of the XML entity escape encoder
// Drives a directed set of source bytes (markup characters, control, plain,
// high and zero bytes) followed by random text, with random idling on both
// channels, a long output hold-off and drain pauses. Checking is done by
// xee_escape_checker; this top only makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module tb_xml_entity_escape_encoder;

  import xee_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int RandomItems  = 200;
  localparam int HoldCycles   = 120;
  localparam int IdlePercent  = 32;
  localparam int SettleCycles = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  xee_byte_if src_if ();
  xee_run_if  dst_if ();

  int fail_count;
  int owed_bytes;
  int cycle_cnt = 0;
  bit quiet     = 1'b0;  // no idling on either side
  bit hold_go   = 1'b0;  // asks the receiver for a long hold-off
  bit hold_done = 1'b0;

  xml_entity_escape_encoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .src_i  (src_if),
    .dst_o  (dst_if)
  );

  xee_escape_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_mon      (src_if),
    .dst_mon      (dst_if),
    .fail_count_o (fail_count),
    .owed_bytes_o (owed_bytes)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one source byte and wait for it to be taken
  task automatic send_byte(input logic [7:0] b);
    if (!quiet) begin
      while ($urandom_range(99) < IdlePercent) begin
        src_if.valid   <= 1'b0;
        src_if.in_byte <= 8'($urandom);
        @(posedge clk_i);
      end
    end
    src_if.valid   <= 1'b1;
    src_if.in_byte <= b;
    @(posedge clk_i);
    while (!src_if.ready) @(posedge clk_i);
  endtask

  // Stop offering until every owed byte has come out
  task automatic wait_drain();
    src_if.valid <= 1'b0;
    @(posedge clk_i);
    while (owed_bytes != 0) @(posedge clk_i);
  endtask

  // Random text byte, weighted toward the escaped classes
  function automatic logic [7:0] pick_text_byte();
    logic [7:0] markup [5];
    int         sel;
    markup = '{B_QUOT, B_AMP, B_APOS, B_LT, B_GT};
    sel    = $urandom_range(99);
    if (sel < 18) return markup[$urandom_range(4)];
    if (sel < 38) return 8'($urandom_range(255, 128));
    if (sel < 48) return 8'($urandom_range(31, 1));
    if (sel < 52) return B_NUL;
    return 8'($urandom_range(127, 32));
  endfunction

  // Output side: random ready, one long hold-off on request
  initial begin
    dst_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        dst_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      dst_if.ready <= quiet || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [7:0] directed [$];
    directed = '{B_NUL, 8'd1, 8'd31, B_SPACE, B_QUOT, B_AMP, B_APOS, B_LT, B_GT,
                 8'd127, B_HIGH, 8'd255, B_200, 8'd199, B_100, 8'd9, B_NUL, B_NUL,
                 8'd65, 8'hAA, 8'h55, 8'd129, 8'd254};
    rst_ni         = 1'b0;
    src_if.valid   = 1'b0;
    src_if.in_byte = 8'h00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed bytes
    foreach (directed[i]) send_byte(directed[i]);
    wait_drain();

    // Random text with a hold-off, a quiet window and drain pauses
    for (int n = 0; n < RandomItems; n++) begin
      if (n == 30) hold_go = 1'b1;
      if (n == 80 || n == 170) wait_drain();
      quiet = (n >= 100 && n < 150);
      send_byte(pick_text_byte());
    end
    quiet = 1'b0;
    wait_drain();
    repeat (SettleCycles) @(posedge clk_i);

    if (owed_bytes != 0) begin
      $display("%0t: %0d expected bytes never came out", $time, owed_bytes);
    end
    if (fail_count == 0 && owed_bytes == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
